### hdl/spa_pkg.sv
// Package for the slot pool allocator: field widths, command and status codes,
// and the structs that pass between the controller and the slot store.
// No dependencies.
`timescale 1ns / 1ps

package spa_pkg;

  localparam int CMD_W    = 3;
  localparam int SLOT_W   = 6;
  localparam int KEY_W    = 32;
  localparam int LIMIT_W  = 7;
  localparam int STATUS_W = 2;

  // Command codes; the two remaining codes are accepted and ignored.
  localparam logic [CMD_W-1:0] CMD_ALLOC    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FREE     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SET_TAG  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FIND_ID  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FIND_TAG = 3'd4;
  localparam logic [CMD_W-1:0] CMD_FIND_ALL = 3'd5;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

  // One result without its last flag.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_index;
    logic [KEY_W-1:0]    entity_id;
  } res_t;

  // Write command into the id and tag memories.
  typedef struct packed {
    logic              we_id;
    logic              we_tag;
    logic [SLOT_W-1:0] addr;
    logic [KEY_W-1:0]  id;
    logic [KEY_W-1:0]  tag;
  } mem_wr_t;

  // Read command into the id and tag memories.
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
  } mem_rd_t;

endpackage

### hdl/spa_if.sv
// Request and result channel interfaces of the slot pool allocator.
// Depends on spa_pkg for the field widths.
`timescale 1ns / 1ps

interface spa_req_if;
  import spa_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [SLOT_W-1:0]  slot;
  logic [KEY_W-1:0]   key;
  logic [LIMIT_W-1:0] limit;

  modport source (output valid, cmd, slot, key, limit, input ready);
  modport sink   (input valid, cmd, slot, key, limit, output ready);
endinterface

interface spa_rsp_if;
  import spa_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot_index;
  logic [KEY_W-1:0]    entity_id;
  logic                last;

  modport source (output valid, status, slot_index, entity_id, last, input ready);
  modport sink   (input valid, status, slot_index, entity_id, last, output ready);
endinterface

### hdl/spa_store.sv
// Slot store: synchronous id and tag memories with one write port and one
// registered read port each. Depends on spa_pkg.
`timescale 1ns / 1ps

module spa_store #(
  parameter int SLOTS = 64
) (
  input  logic             clk,
  input  spa_pkg::mem_wr_t wr,
  input  spa_pkg::mem_rd_t rd,
  output logic [31:0]      rd_id,
  output logic [31:0]      rd_tag
);
  import spa_pkg::*;

  localparam int IW = $clog2(SLOTS);

  logic [KEY_W-1:0] id_mem  [SLOTS];
  logic [KEY_W-1:0] tag_mem [SLOTS];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr.we_id) begin
      id_mem[wr.addr[IW-1:0]] <= wr.id;
    end
    if (wr.we_tag) begin
      tag_mem[wr.addr[IW-1:0]] <= wr.tag;
    end
  end

  // Read port; data holds while the read is not enabled.
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_id  <= id_mem[rd.addr[IW-1:0]];
      rd_tag <= tag_mem[rd.addr[IW-1:0]];
    end
  end

endmodule

### hdl/spa_ctrl.sv
// Controller of the slot pool allocator: command decode, the scan over the
// slot store, active bits, counters and the result register.
// Depends on spa_pkg, spa_if and the read and write ports of spa_store.
`timescale 1ns / 1ps

module spa_ctrl #(
  parameter int SLOTS = 64
) (
  input  logic              clk,
  input  logic              rst,
  spa_req_if.sink           req,
  spa_rsp_if.source         rsp,
  output spa_pkg::mem_wr_t  wr,
  output spa_pkg::mem_rd_t  rd,
  input  logic [31:0]       rd_id,
  input  logic [31:0]       rd_tag
);
  import spa_pkg::*;

  localparam int IW  = $clog2(SLOTS);
  localparam int CW  = $clog2(SLOTS + 1);
  localparam int SW1 = SLOT_W + 1;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FLUSH} state_t;

  state_t             state;
  logic [CMD_W-1:0]   op;
  logic [KEY_W-1:0]   key_r;
  logic [LIMIT_W-1:0] limit_r;
  logic [CW-1:0]      iss;
  logic               ev_valid;
  logic [IW-1:0]      ev_idx;
  logic [LIMIT_W-1:0] found;
  res_t               pend;
  logic               pend_valid;
  res_t               out_r;
  logic               out_last;
  logic               out_valid;
  logic [SLOTS-1:0]   active;
  logic [CW-1:0]      used_count;
  logic [KEY_W-1:0]   id_counter;

  logic               out_free;
  logic               out_load;
  logic               hit;
  logic               scan_hit;
  logic               stall;
  logic               exhausted;
  logic               issue;
  logic               ev_valid_next;
  logic               slot_ok;
  logic               room;
  logic [LIMIT_W-1:0] found_next;

  // Scan bookkeeping: one entry issued and one evaluated per cycle, save in a stall.
  assign out_free   = !out_valid || rsp.ready;
  assign slot_ok    = SW1'(req.slot) < SW1'(SLOTS);
  assign room       = used_count < CW'(SLOTS);
  assign found_next = found + LIMIT_W'(1);

  always_comb begin
    case (op) inside
      CMD_ALLOC:                  hit = !active[ev_idx];
      CMD_FIND_ID:                hit = active[ev_idx] && (rd_id == key_r);
      CMD_FIND_TAG, CMD_FIND_ALL: hit = active[ev_idx] && ((rd_tag & key_r) != '0);
      default:                    hit = 1'b0;
    endcase
  end

  assign scan_hit  = (state == S_SCAN) && ev_valid && hit;
  // A find-all match must push the held result out before it can be held itself.
  assign stall     = scan_hit && (op == CMD_FIND_ALL) && pend_valid && !out_free;
  assign exhausted = (state == S_SCAN) && !ev_valid && (iss == used_count);
  assign issue     = (state == S_SCAN) && !scan_hit && (iss < used_count)
                   || (state == S_SCAN) && scan_hit && !stall && (op == CMD_FIND_ALL)
                      && (found_next != limit_r) && (iss < used_count);
  assign ev_valid_next = issue || (stall && ev_valid);

  // The result register takes the final result, or a held find-all match that
  // a later match has shown not to be the final one.
  assign out_load = ((state == S_FLUSH) && out_free)
                  || (scan_hit && !stall && (op == CMD_FIND_ALL) && pend_valid);

  assign rd.en   = issue;
  assign rd.addr = SLOT_W'(iss[IW-1:0]);

  // Memory writes: set tag at acceptance, id and cleared tag on a successful alloc.
  always_comb begin
    wr = '0;
    if ((state == S_IDLE) && req.valid && (req.cmd == CMD_SET_TAG) && slot_ok) begin
      wr.we_tag = 1'b1;
      wr.addr   = req.slot;
      wr.tag    = req.key;
    end else if (scan_hit && (op == CMD_ALLOC)) begin
      wr.we_id  = 1'b1;
      wr.we_tag = 1'b1;
      wr.addr   = SLOT_W'(ev_idx);
      wr.id     = id_counter;
    end else if (exhausted && (op == CMD_ALLOC) && room) begin
      wr.we_id  = 1'b1;
      wr.we_tag = 1'b1;
      wr.addr   = SLOT_W'(used_count[IW-1:0]);
      wr.id     = id_counter;
    end
  end

  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.status     = out_r.status;
  assign rsp.slot_index = out_r.slot_index;
  assign rsp.entity_id  = out_r.entity_id;
  assign rsp.last       = out_last;

  // State, counters, active bits and the result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      iss        <= '0;
      ev_valid   <= 1'b0;
      found      <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      active     <= '0;
      used_count <= '0;
      id_counter <= '0;
    end else begin
      ev_valid <= ev_valid_next;
      if (issue) begin
        ev_idx <= iss[IW-1:0];
        iss    <= iss + CW'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            op      <= req.cmd;
            key_r   <= req.key;
            limit_r <= req.limit;
            iss     <= '0;
            found   <= '0;
            case (req.cmd) inside
              CMD_ALLOC, CMD_FIND_ID, CMD_FIND_TAG: begin
                state <= S_SCAN;
              end
              CMD_FIND_ALL: begin
                if (req.limit == '0) begin
                  pend       <= '{ST_NOTFOUND, '0, '0};
                  pend_valid <= 1'b1;
                  state      <= S_FLUSH;
                end else begin
                  state <= S_SCAN;
                end
              end
              CMD_FREE, CMD_SET_TAG: begin
                if (slot_ok) begin
                  if (req.cmd == CMD_FREE) begin
                    active[req.slot[IW-1:0]] <= 1'b0;
                  end
                  pend <= '{ST_OK, req.slot, '0};
                end else begin
                  pend <= '{ST_NOTFOUND, req.slot, '0};
                end
                pend_valid <= 1'b1;
                state      <= S_FLUSH;
              end
              default: begin
              end
            endcase
          end
        end

        S_SCAN: begin
          if (scan_hit && !stall) begin
            case (op) inside
              CMD_ALLOC: begin
                active[ev_idx] <= 1'b1;
                pend           <= '{ST_OK, SLOT_W'(ev_idx), id_counter};
                id_counter     <= id_counter + KEY_W'(1);
                pend_valid     <= 1'b1;
                state          <= S_FLUSH;
              end
              CMD_FIND_ALL: begin
                // The held match is now known not to be the final one.
                if (pend_valid) begin
                  out_r    <= pend;
                  out_last <= 1'b0;
                end
                pend       <= '{ST_OK, SLOT_W'(ev_idx), rd_id};
                pend_valid <= 1'b1;
                found      <= found_next;
                if (found_next == limit_r) begin
                  state <= S_FLUSH;
                end
              end
              default: begin
                pend       <= '{ST_OK, SLOT_W'(ev_idx), rd_id};
                pend_valid <= 1'b1;
                state      <= S_FLUSH;
              end
            endcase
          end else if (exhausted) begin
            case (op) inside
              CMD_ALLOC: begin
                // No free slot below the high-water mark: append or report full.
                if (room) begin
                  active[used_count[IW-1:0]] <= 1'b1;
                  used_count <= used_count + CW'(1);
                  id_counter <= id_counter + KEY_W'(1);
                  pend       <= '{ST_OK, SLOT_W'(used_count[IW-1:0]), id_counter};
                end else begin
                  pend <= '{ST_FULL, '0, '0};
                end
              end
              CMD_FIND_ALL: begin
                if (!pend_valid) begin
                  pend <= '{ST_NOTFOUND, '0, '0};
                end
              end
              default: begin
                pend <= '{ST_NOTFOUND, '0, '0};
              end
            endcase
            pend_valid <= 1'b1;
            state      <= S_FLUSH;
          end
        end

        S_FLUSH: begin
          if (out_free) begin
            out_r      <= pend;
            out_last   <= 1'b1;
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The high-water mark never passes the pool size.
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used_count <= CW'(SLOTS))
    else $error("used count beyond pool size");

  // The final result of a command is always held when flushing.
  a_flush_pend: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH) |-> pend_valid)
    else $error("flush without a held result");

  // A stalled match keeps the entry under evaluation.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    stall |=> (ev_valid && $stable(ev_idx)))
    else $error("stalled scan lost its entry");

endmodule

### hdl/slot_pool_allocator_with_lookup.sv
// Slot pool allocator with id and tag lookup: top level joining controller and store.
// Depends on spa_pkg, spa_if, spa_store and spa_ctrl.
`timescale 1ns / 1ps

// The pool holds SLOTS slots, each with an active bit kept in flip-flops and
// an id and tag mask kept in a synchronous memory, so no clearing pass is
// needed after reset. Alloc, find id, find first tag and find all tag scan the
// slots below the high-water count through the store's read ports, one slot per
// cycle; a match ends an alloc or find scan early, and find all at its limit.
// A find all that meets a busy result channel pauses the scan until its
// earlier match is taken, and any result waiting in the output register
// delays the final one until it is taken.
// Find all delivers one result per match up to its limit, or one not-found
// result when there is none, flagging the final one with last.
// The next request is taken once the final result of the current one sits
// in the output register.

module slot_pool_allocator_with_lookup #(
  parameter int SLOTS = 64
) (
  input  logic      clk,
  input  logic      rst,
  spa_req_if.sink   req,
  spa_rsp_if.source rsp
);
  import spa_pkg::*;

  mem_wr_t     wr;
  mem_rd_t     rd;
  logic [31:0] rd_id;
  logic [31:0] rd_tag;

  spa_ctrl #(.SLOTS(SLOTS)) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .rsp    (rsp),
    .wr     (wr),
    .rd     (rd),
    .rd_id  (rd_id),
    .rd_tag (rd_tag)
  );

  spa_store #(.SLOTS(SLOTS)) u_store (
    .clk    (clk),
    .wr     (wr),
    .rd     (rd),
    .rd_id  (rd_id),
    .rd_tag (rd_tag)
  );

endmodule

### tb/tb_top.sv
// Self-checking bench for the slot pool allocator: drives request items, predicts the results
// and checks every result in order. Depends on spa_pkg, spa_if and the top level of the block.
`timescale 1ns / 1ps

module tb_top;
  import spa_pkg::*;

  localparam int POOL = 64;
  localparam int TAIL_CYCLES = 100;

  // The two command codes that the block takes and ignores.
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_index;
    logic [KEY_W-1:0]    entity_id;
    logic                last;
  } pool_rsp_t;

  logic clk;
  logic rst;

  spa_req_if req_ch ();
  spa_rsp_if rsp_ch ();

  slot_pool_allocator_with_lookup #(
    .SLOTS(POOL)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Own copy of the pool state.
  logic             live [POOL];
  logic [KEY_W-1:0] slot_ids [POOL];
  logic [KEY_W-1:0] slot_tags [POOL];
  int               hw_count;
  logic [KEY_W-1:0] next_id;

  pool_rsp_t awaited_rsp [$];

  int src_idle_pct;
  int rcv_idle_pct;
  int stall_left;
  int errors;
  int n_reqs;
  int n_rsps;
  int n_full;
  int n_bursts;

  // Clock.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // One line per mismatch; the count decides the verdict.
  task automatic report_mismatch(input string what, input logic [KEY_W-1:0] want,
                                 input logic [KEY_W-1:0] got);
    $display("Mismatch at %0t: %s, wanted 0x%0h, got 0x%0h", $realtime, what, want, got);
    errors++;
  endtask

  function automatic void await_rsp(input logic [STATUS_W-1:0] st, input int idx,
                                    input logic [KEY_W-1:0] id, input logic lst);
    pool_rsp_t r;
    r.status     = st;
    r.slot_index = idx[SLOT_W-1:0];
    r.entity_id  = id;
    r.last       = lst;
    awaited_rsp.push_back(r);
  endfunction

  // Applies one accepted request to the pool copy and queues the results it causes.
  task automatic pool_apply(input logic [CMD_W-1:0] c, input logic [SLOT_W-1:0] s,
                            input logic [KEY_W-1:0] k, input logic [LIMIT_W-1:0] lim);
    int n;
    int pick;
    int hits [$];
    bit hit;
    n = (hw_count < POOL) ? hw_count : POOL;
    case (c)
      CMD_ALLOC: begin
        pick = -1;
        for (int i = 0; i < n; i++) begin
          if (!live[i]) begin
            pick = i;
            break;
          end
        end
        if (pick < 0 && hw_count >= POOL) begin
          await_rsp(ST_FULL, 0, '0, 1'b1);
          n_full++;
        end else begin
          if (pick < 0) begin
            pick = hw_count;
            hw_count++;
          end
          live[pick]      = 1'b1;
          slot_tags[pick] = '0;
          slot_ids[pick]  = next_id;
          await_rsp(ST_OK, pick, next_id, 1'b1);
          next_id = next_id + 1'b1;
        end
      end
      CMD_FREE, CMD_SET_TAG: begin
        if (int'(s) >= POOL) begin
          await_rsp(ST_NOTFOUND, int'(s), '0, 1'b1);
        end else begin
          if (c == CMD_FREE)
            live[s] = 1'b0;
          else
            slot_tags[s] = k;
          await_rsp(ST_OK, int'(s), '0, 1'b1);
        end
      end
      CMD_FIND_ID, CMD_FIND_TAG: begin
        pick = -1;
        for (int i = 0; i < n; i++) begin
          hit = (c == CMD_FIND_ID) ? (slot_ids[i] == k) : ((slot_tags[i] & k) != '0);
          if (live[i] && hit) begin
            pick = i;
            break;
          end
        end
        if (pick < 0)
          await_rsp(ST_NOTFOUND, 0, '0, 1'b1);
        else
          await_rsp(ST_OK, pick, slot_ids[pick], 1'b1);
      end
      CMD_FIND_ALL: begin
        for (int i = 0; i < n && hits.size() < int'(lim); i++) begin
          if (live[i] && (slot_tags[i] & k) != '0)
            hits.push_back(i);
        end
        if (hits.size() == 0) begin
          await_rsp(ST_NOTFOUND, 0, '0, 1'b1);
        end else begin
          foreach (hits[j])
            await_rsp(ST_OK, hits[j], slot_ids[hits[j]], j == hits.size() - 1);
          if (hits.size() > 1)
            n_bursts++;
        end
      end
      default: ;
    endcase
  endtask

  // Offers one request, idling first at the sender's rate, and predicts it on acceptance.
  task automatic send_req(input logic [CMD_W-1:0] c, input logic [SLOT_W-1:0] s,
                          input logic [KEY_W-1:0] k, input logic [LIMIT_W-1:0] lim);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.cmd   <= c;
    req_ch.slot  <= s;
    req_ch.key   <= k;
    req_ch.limit <= lim;
    @(posedge clk);
    while (!req_ch.ready)
      @(posedge clk);
    pool_apply(c, s, k, lim);
    n_reqs++;
  endtask

  // The sender stops until every awaited result has come back.
  task automatic wait_drained();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (awaited_rsp.size() != 0)
      @(negedge clk);
  endtask

  // Receiver: a long hold-off when one is pending, otherwise random idling.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // Each accepted result is compared with the oldest awaited one.
  always @(posedge clk) begin
    pool_rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      n_rsps++;
      if (awaited_rsp.size() == 0) begin
        report_mismatch("result with nothing awaited, slot_index", '0,
                        KEY_W'(rsp_ch.slot_index));
      end else begin
        want = awaited_rsp.pop_front();
        if (rsp_ch.status !== want.status)
          report_mismatch("status", KEY_W'(want.status), KEY_W'(rsp_ch.status));
        if (rsp_ch.slot_index !== want.slot_index)
          report_mismatch("slot_index", KEY_W'(want.slot_index), KEY_W'(rsp_ch.slot_index));
        if (rsp_ch.entity_id !== want.entity_id)
          report_mismatch("entity_id", want.entity_id, rsp_ch.entity_id);
        if (rsp_ch.last !== want.last)
          report_mismatch("last", KEY_W'(want.last), KEY_W'(rsp_ch.last));
      end
    end
  end

  // Helpers: a random live slot (any slot if none is live) and the count of free slots.
  function automatic int pick_live_slot();
    int cand [$];
    for (int i = 0; i < POOL; i++)
      if (live[i]) cand.push_back(i);
    if (cand.size() == 0)
      return $urandom_range(POOL - 1);
    return cand[$urandom_range(cand.size() - 1)];
  endfunction

  function automatic int free_slot_count();
    int cnt;
    cnt = 0;
    for (int i = 0; i < POOL; i++)
      if (!live[i]) cnt++;
    return cnt;
  endfunction

  // Tag masks mostly draw on the six low bits so that lookups find several matches.
  function automatic logic [KEY_W-1:0] rand_mask();
    case ($urandom_range(4))
      0, 1: return KEY_W'(1) << $urandom_range(5);
      2:    return (KEY_W'(1) << $urandom_range(5)) | (KEY_W'(1) << $urandom_range(31));
      3:    return $urandom;
      default: return ($urandom_range(1) == 1) ? '1 : '0;
    endcase
  endfunction

  task automatic rand_req();
    int roll;
    logic [CMD_W-1:0]   c;
    logic [SLOT_W-1:0]  s;
    logic [KEY_W-1:0]   k;
    logic [LIMIT_W-1:0] lim;
    roll = $urandom_range(99);
    s    = SLOT_W'($urandom_range(POOL - 1));
    k    = $urandom;
    lim  = LIMIT_W'($urandom_range(127));
    if (roll < 25) begin
      c = CMD_ALLOC;
    end else if (roll < 38) begin
      c = CMD_FREE;
      if ($urandom_range(9) < 7) s = SLOT_W'(pick_live_slot());
    end else if (roll < 58) begin
      c = CMD_SET_TAG;
      if ($urandom_range(9) < 8) s = SLOT_W'(pick_live_slot());
      k = rand_mask();
    end else if (roll < 70) begin
      c = CMD_FIND_ID;
      case ($urandom_range(4))
        0, 1, 2: k = slot_ids[pick_live_slot()];
        3:       k = slot_ids[$urandom_range(POOL - 1)];
        default: ;
      endcase
    end else if (roll < 80) begin
      c = CMD_FIND_TAG;
      k = rand_mask();
    end else if (roll < 97) begin
      c = CMD_FIND_ALL;
      k = rand_mask();
      case ($urandom_range(9))
        0, 1, 2, 3, 4: lim = LIMIT_W'($urandom_range(1, 8));
        5, 6, 7:       lim = LIMIT_W'($urandom_range(0, POOL));
        default:       lim = LIMIT_W'($urandom_range(127));
      endcase
    end else begin
      c = ($urandom_range(1) == 1) ? CMD_SPARE_A : CMD_SPARE_B;
    end
    send_req(c, s, k, lim);
  endtask

  // Lookups on an empty pool find nothing.
  task automatic test_empty_pool();
    send_req(CMD_FIND_ID, 6'd0, 32'h0, 7'd0);
    send_req(CMD_FIND_TAG, 6'd63, 32'hFFFF_FFFF, 7'd127);
    send_req(CMD_FIND_ALL, 6'd0, 32'hFFFF_FFFF, 7'd64);
  endtask

  // Appending allocs, tag writes and the lookups over them.
  task automatic test_alloc_and_tags();
    send_req(CMD_ALLOC, 6'd63, 32'hFFFF_FFFF, 7'd127);
    send_req(CMD_ALLOC, 6'd0, 32'h0, 7'd0);
    send_req(CMD_ALLOC, 6'd21, 32'h5A5A_A5A5, 7'd5);
    send_req(CMD_SET_TAG, 6'd1, 32'hFFFF_FFFF, 7'd0);
    send_req(CMD_SET_TAG, 6'd2, 32'h8000_0001, 7'd0);
    // A tag written to a slot that is not active.
    send_req(CMD_SET_TAG, 6'd63, 32'hFFFF_FFFF, 7'd0);
    send_req(CMD_FIND_TAG, 6'd0, 32'h0000_0001, 7'd0);
    // A limit beyond the pool is never reached.
    send_req(CMD_FIND_ALL, 6'd0, 32'h0000_0001, 7'd127);
    send_req(CMD_FIND_ALL, 6'd0, 32'hFFFF_FFFF, 7'd0);
    send_req(CMD_FIND_ALL, 6'd0, 32'h8000_0000, 7'd1);
    send_req(CMD_FIND_ID, 6'd0, 32'h0000_0002, 7'd0);
    send_req(CMD_FIND_ID, 6'd0, 32'hFFFF_FFFF, 7'd0);
  endtask

  // Frees, including one of a slot never used, then reuse of the lowest hole.
  task automatic test_free_and_reuse();
    send_req(CMD_FREE, 6'd1, 32'h0, 7'd0);
    send_req(CMD_FREE, 6'd63, 32'h0, 7'd0);
    send_req(CMD_FIND_TAG, 6'd0, 32'h0000_0001, 7'd0);
    send_req(CMD_ALLOC, 6'd0, 32'h0, 7'd0);
    send_req(CMD_FIND_ALL, 6'd0, 32'hFFFF_FFFF, 7'd64);
    send_req(CMD_FIND_ID, 6'd0, 32'h0000_0003, 7'd0);
  endtask

  // Unused command codes change nothing and return nothing.
  task automatic test_spare_codes();
    send_req(CMD_SPARE_A, 6'd63, 32'hFFFF_FFFF, 7'd127);
    send_req(CMD_SPARE_B, 6'd0, 32'h0, 7'd0);
  endtask

  // Fills the pool while the receiver holds off, hits pool full, then a find all
  // that reports every slot, one stopped by its limit and one more alloc on the full pool.
  task automatic test_fill_under_backpressure();
    stall_left = 300;
    while (free_slot_count() != 0)
      send_req(CMD_ALLOC, SLOT_W'($urandom_range(POOL - 1)), $urandom,
               LIMIT_W'($urandom_range(127)));
    send_req(CMD_ALLOC, SLOT_W'($urandom_range(POOL - 1)), $urandom,
             LIMIT_W'($urandom_range(127)));
    wait_drained();
    for (int i = 0; i < POOL; i++)
      send_req(CMD_SET_TAG, i[SLOT_W-1:0], 32'h1 | $urandom, 7'd0);
    stall_left = 200;
    send_req(CMD_FIND_ALL, 6'd0, 32'h0000_0001, 7'd64);
    send_req(CMD_FIND_ALL, 6'd0, 32'h0000_0001, 7'd63);
    send_req(CMD_ALLOC, 6'd0, 32'h0, 7'd0);
    wait_drained();
  endtask

  task automatic test_random_mix(input int count);
    for (int i = 0; i < count; i++)
      rand_req();
  endtask

  // Overall time limit.
  initial begin
    #(64'd10_000_000);
    $display("FAIL");
    $finish;
  end

  initial begin
    rst          = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.cmd   = CMD_ALLOC;
    req_ch.slot  = '0;
    req_ch.key   = '0;
    req_ch.limit = '0;
    src_idle_pct = 14;
    rcv_idle_pct = 66;
    stall_left   = 0;
    errors       = 0;
    n_reqs       = 0;
    n_rsps       = 0;
    n_full       = 0;
    n_bursts     = 0;
    hw_count     = 0;
    next_id      = '0;
    for (int i = 0; i < POOL; i++) begin
      live[i]      = 1'b0;
      slot_ids[i]  = '0;
      slot_tags[i] = '0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_pool();
    test_alloc_and_tags();
    test_free_and_reuse();
    test_spare_codes();
    test_random_mix(45);

    src_idle_pct = 66;
    rcv_idle_pct = 14;
    test_random_mix(45);
    test_fill_under_backpressure();

    src_idle_pct = 0;
    rcv_idle_pct = 0;
    test_random_mix(40);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d requests and %0d results over all commands and idling mixes,",
             n_reqs, n_rsps);
    $display("with %0d pool-full answers and %0d multi-result find-all bursts.",
             n_full, n_bursts);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches found.", errors);
      $display("FAIL");
    end
    $finish;
  end

endmodule
